// ----- rtl/core/fixed_slot_pool_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FSPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fspa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared field widths, operation and status codes, and the control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

  localparam int NumSlotsDef  = 64;
  localparam int SlotBytesDef = 1024;

  localparam int OpW       = 2;
  localparam int SizeW     = 16;
  localparam int AddrW     = 17;
  localparam int StoreW    = 10;
  localparam int StatusW   = 2;
  localparam int ResAddrW  = 16;
  localparam int CopyW     = 10;
  localparam int CountOutW = 7;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_ADDR    = 2'd0,
    ST_NULL    = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  // action on the free stack; top of stack is the free list head
  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_POP  = 2'd1,
    STK_PUSH = 2'd2,
    STK_SWAP = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t stk_op;
    logic    size_wr;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/fixed_slot_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// Allocate, free and reallocate equal slots from a LIFO free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: op,
//   req_size, addr, addr_is_null. Output channel (out_valid/out_ready)
//   returns exactly one result item per request: status, result_addr,
//   copy_len, slots_in_use.
//   An item taken into the input register moves on into the result register,
//   with out_valid high, once the result register is empty or its item is taken.
//   The decode, the free stack head and the stored size lookup sit between
//   the two registers. Throughput is one item per cycle while the receiver
//   does not stall; the stored size memory is read at accept time, so its
//   registered read port sets the input register stage.
//   While the receiver stalls, the result register holds and one more item
//   is still taken into the input register; after that in_ready drops.
//   Reset empties both registers, links the free list in slot order, clears
//   all in-use marks and the use count. No clearing pass: the stored size of a
//   slot is written by each allocation of it and is undefined until then.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator_top #(
  parameter int NUM_SLOTS  = fspa_pkg::NumSlotsDef,
  parameter int SLOT_BYTES = fspa_pkg::SlotBytesDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fspa_pkg::OpW-1:0]       op,
  input  logic [fspa_pkg::SizeW-1:0]     req_size,
  input  logic [fspa_pkg::AddrW-1:0]     addr,
  input  logic                           addr_is_null,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fspa_pkg::StatusW-1:0]   status,
  output logic [fspa_pkg::ResAddrW-1:0]  result_addr,
  output logic [fspa_pkg::CopyW-1:0]     copy_len,
  output logic [fspa_pkg::CountOutW-1:0] slots_in_use
);
  import fspa_pkg::*;

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int ExtW = CntW + CountOutW;

  // input register
  logic             it_valid;
  logic [OpW-1:0]   it_op;
  logic [SizeW-1:0] it_size;
  logic [AddrW-1:0] it_addr;
  logic             it_null;

  logic advance;
  logic accept;

  logic [IdxW-1:0]     ns;
  logic [IdxW-1:0]     os;
  logic                empty;
  logic                os_in_use;
  logic [CntW-1:0]     cnt_next;
  logic [ExtW-1:0]     cnt_ext;
  logic [StoreW-1:0]   old_size;
  ctrl_t               ctrl;
  status_t             dec_status;
  logic [ResAddrW-1:0] dec_addr;
  logic [CopyW-1:0]    dec_copy;

  assign advance  = it_valid && (!out_valid || out_ready);
  assign in_ready = !it_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      it_valid <= 1'b0;
    end else if (accept) begin
      it_valid <= 1'b1;
    end else if (advance) begin
      it_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_op   <= op;
      it_size <= req_size;
      it_addr <= addr;
      it_null <= addr_is_null;
    end
  end

  fspa_size_ram #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_size_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (addr),
    .wr_en   (advance && ctrl.size_wr),
    .wr_slot (ns),
    .wr_data (it_size[StoreW-1:0]),
    .rd_data (old_size)
  );

  fspa_slot_state #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_state (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .stk_op    (ctrl.stk_op),
    .os        (os),
    .ns        (ns),
    .empty     (empty),
    .os_in_use (os_in_use),
    .cnt_next  (cnt_next)
  );

  fspa_decide #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_decide (
    .op           (it_op),
    .req_size     (it_size),
    .addr         (it_addr),
    .addr_is_null (it_null),
    .ns           (ns),
    .empty        (empty),
    .os_in_use    (os_in_use),
    .old_size     (old_size),
    .os           (os),
    .ctrl         (ctrl),
    .status       (dec_status),
    .result_addr  (dec_addr),
    .copy_len     (dec_copy)
  );

  assign cnt_ext = ExtW'(cnt_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= dec_status;
      result_addr  <= dec_addr;
      copy_len     <= dec_copy;
      slots_in_use <= cnt_ext[CountOutW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fspa_slot_state.sv -----
// ----------------------------------------------------------------------------
// Slot state
// Free list kept as a shift-register stack, in-use marks and use count.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_slot_state #(
  parameter int NUM_SLOTS = fspa_pkg::NumSlotsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  fspa_pkg::stk_op_t             stk_op,
  input  logic [$clog2(NUM_SLOTS)-1:0]  os,
  output logic [$clog2(NUM_SLOTS)-1:0]  ns,
  output logic                          empty,
  output logic                          os_in_use,
  output logic [$clog2(NUM_SLOTS+1)-1:0] cnt_next
);
  import fspa_pkg::*;

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  logic [IdxW-1:0]      stk [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] in_use;
  logic [CntW-1:0]      cnt;

  assign ns        = stk[0];
  assign empty     = (cnt == CntW'(NUM_SLOTS));
  assign os_in_use = in_use[os];

  always_comb begin
    cnt_next = cnt;
    case (stk_op)
      STK_POP:  cnt_next = cnt + CntW'(1);
      STK_PUSH: cnt_next = cnt - CntW'(1);
      default:  cnt_next = cnt;
    endcase
  end

  // entry 0 is the head; pop shifts up, push shifts down
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_stk
    logic [IdxW-1:0] below;
    logic [IdxW-1:0] above;

    if (i == NUM_SLOTS - 1) begin : g_last
      assign below = stk[i];
    end else begin : g_mid
      assign below = stk[i+1];
    end

    if (i == 0) begin : g_head
      assign above = os;
    end else begin : g_rest
      assign above = stk[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stk[i] <= IdxW'(i);
      end else if (fire) begin
        case (stk_op)
          STK_POP:  stk[i] <= below;
          STK_PUSH: stk[i] <= above;
          STK_SWAP: stk[i] <= (i == 0) ? os : stk[i];
          default:  stk[i] <= stk[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      cnt    <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
      case (stk_op)
        STK_POP: begin
          in_use[ns] <= 1'b1;
        end
        STK_PUSH: begin
          in_use[os] <= 1'b0;
        end
        STK_SWAP: begin
          in_use[ns] <= 1'b1;
          in_use[os] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fspa_size_ram.sv -----
// ----------------------------------------------------------------------------
// Stored size memory
// Per-slot request size; read at accept time, with a one-deep bypass of
// the write made by the item processed in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_size_ram #(
  parameter int NUM_SLOTS  = fspa_pkg::NumSlotsDef,
  parameter int SLOT_BYTES = fspa_pkg::SlotBytesDef
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [fspa_pkg::AddrW-1:0]   rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_slot,
  input  logic [fspa_pkg::StoreW-1:0]  wr_data,
  output logic [fspa_pkg::StoreW-1:0]  rd_data
);
  import fspa_pkg::*;

  localparam int IdxW      = $clog2(NUM_SLOTS);
  localparam int SlotShift = $clog2(SLOT_BYTES);

  logic [StoreW-1:0] mem [NUM_SLOTS];
  logic [StoreW-1:0] rd_q;
  logic              byp_hit;
  logic [StoreW-1:0] byp_data;
  logic [IdxW-1:0]   rd_slot;

  assign rd_slot = IdxW'(rd_addr >> SlotShift);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_hit  <= wr_en && (wr_slot == rd_slot);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_q;

endmodule

`default_nettype wire

// ----- rtl/core/fspa_decide.sv -----
// ----------------------------------------------------------------------------
// Request decode
// Decides status, stack action, block address and copy length for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_decide #(
  parameter int NUM_SLOTS  = fspa_pkg::NumSlotsDef,
  parameter int SLOT_BYTES = fspa_pkg::SlotBytesDef
) (
  input  logic [fspa_pkg::OpW-1:0]      op,
  input  logic [fspa_pkg::SizeW-1:0]    req_size,
  input  logic [fspa_pkg::AddrW-1:0]    addr,
  input  logic                          addr_is_null,
  input  logic [$clog2(NUM_SLOTS)-1:0]  ns,
  input  logic                          empty,
  input  logic                          os_in_use,
  input  logic [fspa_pkg::StoreW-1:0]   old_size,
  output logic [$clog2(NUM_SLOTS)-1:0]  os,
  output fspa_pkg::ctrl_t               ctrl,
  output fspa_pkg::status_t             status,
  output logic [fspa_pkg::ResAddrW-1:0] result_addr,
  output logic [fspa_pkg::CopyW-1:0]    copy_len
);
  import fspa_pkg::*;

  localparam int IdxW      = $clog2(NUM_SLOTS);
  localparam int SlotShift = $clog2(SLOT_BYTES);
  localparam int PoolBytes = NUM_SLOTS * SLOT_BYTES;
  localparam int PoolW     = $clog2(PoolBytes + 1);
  localparam int CmpW      = (PoolW > AddrW) ? PoolW : AddrW;
  localparam int SumW0     = IdxW + SlotShift + 1;
  localparam int SumW      = (SumW0 > AddrW) ? SumW0 : AddrW;
  localparam int SizeCmpW  = SizeW + 1;

  logic              size_zero;
  logic              too_big;
  logic              alloc_ok;
  logic              addr_ok;
  logic              same_slot;
  logic [SumW-1:0]   where;
  logic [StoreW-1:0] old_eff;
  logic [StoreW-1:0] min_len;

  assign size_zero = (req_size == '0);
  assign too_big   = (SizeCmpW'(req_size) >= SizeCmpW'(SLOT_BYTES));
  assign alloc_ok  = !size_zero && !too_big && !empty;
  assign addr_ok   = (CmpW'(addr) < CmpW'(PoolBytes));
  assign os        = IdxW'(addr >> SlotShift);
  assign same_slot = (os == ns);

  // block sits at the end of its slot
  assign where = (SumW'(ns) << SlotShift) + SumW'(SLOT_BYTES) - SumW'(req_size);

  // old block in the slot just taken: its size was overwritten first
  assign old_eff = same_slot ? req_size[StoreW-1:0] : old_size;
  assign min_len = (SizeW'(old_eff) < req_size) ? old_eff : req_size[StoreW-1:0];

  always_comb begin
    status       = ST_NULL;
    ctrl.stk_op  = STK_HOLD;
    ctrl.size_wr = 1'b0;
    copy_len     = '0;
    case (op)
      OP_ALLOC: begin
        if (size_zero) begin
          status = ST_NULL;
        end else if (!alloc_ok) begin
          status = ST_OOM;
        end else begin
          status       = ST_ADDR;
          ctrl.stk_op  = STK_POP;
          ctrl.size_wr = 1'b1;
        end
      end
      OP_FREE: begin
        if (addr_is_null) begin
          status = ST_NULL;
        end else if (!addr_ok) begin
          status = ST_BADADDR;
        end else begin
          status = ST_NULL;
          if (os_in_use) begin
            ctrl.stk_op = STK_PUSH;
          end
        end
      end
      OP_REALLOC: begin
        if (size_zero) begin
          if (addr_is_null) begin
            status = ST_NULL;
          end else if (!addr_ok) begin
            status = ST_BADADDR;
          end else begin
            status = ST_NULL;
            if (os_in_use) begin
              ctrl.stk_op = STK_PUSH;
            end
          end
        end else if (!alloc_ok) begin
          status = ST_OOM;
        end else if (addr_is_null) begin
          status       = ST_ADDR;
          ctrl.stk_op  = STK_POP;
          ctrl.size_wr = 1'b1;
        end else if (!addr_ok) begin
          // new block taken and handed straight back; only its size sticks
          status       = ST_BADADDR;
          ctrl.size_wr = 1'b1;
        end else begin
          status       = ST_ADDR;
          ctrl.size_wr = 1'b1;
          copy_len     = min_len;
          if (same_slot) begin
            ctrl.stk_op = STK_HOLD;
          end else if (os_in_use) begin
            ctrl.stk_op = STK_SWAP;
          end else begin
            ctrl.stk_op = STK_POP;
          end
        end
      end
      default: begin
        status = ST_NULL;
      end
    endcase
  end

  assign result_addr = (status == ST_ADDR) ? where[ResAddrW-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/core/fspa_checker.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_slot_pool_allocator_top_defines.svh"

module fspa_checker #(
  parameter int NUM_SLOTS = fspa_pkg::NumSlotsDef
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fspa_pkg::StatusW-1:0]   status,
  input logic [fspa_pkg::ResAddrW-1:0]  result_addr,
  input logic [fspa_pkg::CopyW-1:0]     copy_len,
  input logic [fspa_pkg::CountOutW-1:0] slots_in_use
);
  import fspa_pkg::*;

  localparam int ResW = StatusW + ResAddrW + CopyW + CountOutW;

  logic            out_stall;
  logic            not_addr;
  logic            res_clear;
  logic [ResW-1:0] res_bus;

  assign out_stall = out_valid && !out_ready;
  assign not_addr  = out_valid && (status != ST_ADDR);
  assign res_clear = (result_addr == '0) && (copy_len == '0);
  assign res_bus   = {status, result_addr, copy_len, slots_in_use};

  `FSPA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_bus), "result changed in stall")

  `FSPA_ASSERT_IMPL(a_no_addr_zero, not_addr, res_clear, "address without an address result")

  `FSPA_ASSERT_IMPL(a_count_range, out_valid, int'(slots_in_use) <= NUM_SLOTS, "use count too high")

endmodule

bind fixed_slot_pool_allocator_top fspa_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_fspa_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives allocate, free and reallocate requests with random handshake gaps
// on both channels. A local copy of the free list predicts each result not typed
// in by hand, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module tb;

  import fspa_pkg::*;

  localparam int NUM_SLOTS   = NumSlotsDef;
  localparam int SLOT_BYTES  = SlotBytesDef;
  localparam int PoolBytes   = NUM_SLOTS * SLOT_BYTES;
  localparam int AddrSpan    = (1 << AddrW) - 1;
  localparam int SizeSpan    = (1 << SizeW) - 1;
  localparam int RandomItems = 1750;
  localparam int DirRows     = 20;
  localparam int PhaseLen    = 150;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    status_t                status;
    logic [ResAddrW-1:0]    addr;
    logic [CopyW-1:0]       copy;
    logic [CountOutW-1:0]   count;
  } pool_result_t;

  typedef struct packed {
    logic [OpW-1:0]   opc;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] a;
    logic             nul;
    logic             typed;
    pool_result_t     want;
  } req_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OpW-1:0]       op = '0;
  logic [SizeW-1:0]     req_size = '0;
  logic [AddrW-1:0]     addr = '0;
  logic                 addr_is_null = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [StatusW-1:0]   status;
  logic [ResAddrW-1:0]  result_addr;
  logic [CopyW-1:0]     copy_len;
  logic [CountOutW-1:0] slots_in_use;

  // local copy of the allocator state
  int free_head;
  int next_free  [NUM_SLOTS];
  bit in_use     [NUM_SLOTS];
  int slot_size  [NUM_SLOTS];
  bit size_known [NUM_SLOTS];
  int use_count;

  pool_result_t pending_results [$];
  bit           steady = 1'b0;
  int           mismatches = 0;
  int           results_seen = 0;
  int           requests_sent = 0;
  int           empty_hits = 0;
  int           peak_use = 0;
  int           status_seen [4] = '{0, 0, 0, 0};

  fixed_slot_pool_allocator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .req_size     (req_size),
    .addr         (addr),
    .addr_is_null (addr_is_null),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_addr  (result_addr),
    .copy_len     (copy_len),
    .slots_in_use (slots_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // pop the head slot; returns the status of the allocation
  function automatic status_t take_slot(int size, output int slot);
    slot = 0;
    if (size == 0) return ST_NULL;
    if (size >= SLOT_BYTES) return ST_OOM;
    if (free_head >= NUM_SLOTS) begin
      empty_hits++;
      return ST_OOM;
    end
    slot = free_head;
    free_head = next_free[slot];
    if (!in_use[slot]) use_count++;
    in_use[slot] = 1'b1;
    slot_size[slot] = size;
    size_known[slot] = 1'b1;
    if (use_count > peak_use) peak_use = use_count;
    return ST_ADDR;
  endfunction

  function automatic void give_back(int slot);
    if (!in_use[slot]) return;
    in_use[slot] = 1'b0;
    if (use_count > 0) use_count--;
    next_free[slot] = free_head;
    free_head = slot;
  endfunction

  function automatic status_t release_addr(logic nul, int a);
    if (nul) return ST_NULL;
    if (a >= PoolBytes) return ST_BADADDR;
    give_back(a / SLOT_BYTES);
    return ST_NULL;
  endfunction

  function automatic pool_result_t pool_step(logic [OpW-1:0] opc, int size, int a,
                                             logic nul);
    pool_result_t r;
    int ns;
    int os;
    int old;
    r = '0;
    r.status = ST_NULL;
    ns = 0;
    case (opc)
      OP_ALLOC: r.status = take_slot(size, ns);
      OP_FREE:  r.status = release_addr(nul, a);
      OP_REALLOC: begin
        if (size == 0) begin
          r.status = release_addr(nul, a);
        end else begin
          r.status = take_slot(size, ns);
          if (r.status == ST_ADDR && !nul) begin
            if (a >= PoolBytes) begin
              // new block is taken, then handed straight back
              give_back(ns);
              r.status = ST_BADADDR;
            end else begin
              os = a / SLOT_BYTES;
              old = slot_size[os];
              r.copy = CopyW'((old < size) ? old : size);
              give_back(os);
            end
          end
        end
      end
      default: ;
    endcase
    if (r.status == ST_ADDR) r.addr = ResAddrW'(ns * SLOT_BYTES + SLOT_BYTES - size);
    r.count = CountOutW'(use_count);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_seen[status]++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item, status", -1, status);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) flag_mismatch("status", want.status, status);
        if (result_addr !== want.addr) flag_mismatch("result_addr", want.addr, result_addr);
        if (copy_len !== want.copy) flag_mismatch("copy_len", want.copy, copy_len);
        if (slots_in_use !== want.count)
          flag_mismatch("slots_in_use", want.count, slots_in_use);
      end
    end
  end

  // presents one item at a falling edge, returns at the accepting edge
  task automatic send_request(logic [OpW-1:0] opc, logic [SizeW-1:0] size,
                              logic [AddrW-1:0] a, logic nul, logic typed,
                              pool_result_t want);
    pool_result_t got;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= opc;
    req_size     <= size;
    addr         <= a;
    addr_is_null <= nul;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = pool_step(opc, size, a, nul);
    pending_results.push_back(typed ? want : got);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    req_row_t         directed_rows [DirRows];
    logic [OpW-1:0]   opc;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] a;
    logic             nul;
    bit               grow;
    int               k;
    int               s;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      next_free[i]  = i + 1;
      in_use[i]     = 1'b0;
      slot_size[i]  = 0;
      size_known[i] = 1'b0;
    end
    free_head = 0;
    use_count = 0;

    // expected values are typed in where they follow directly from reset
    directed_rows = '{
      '{OP_ALLOC,   16'd0,     17'd0,      1'b0, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd0}},
      '{OP_ALLOC,   16'd1024,  17'd0,      1'b0, 1'b1, '{ST_OOM,     16'd0,    10'd0, 7'd0}},
      '{OP_ALLOC,   16'hFFFF,  17'd0,      1'b0, 1'b1, '{ST_OOM,     16'd0,    10'd0, 7'd0}},
      '{OP_ALLOC,   16'd1,     17'd0,      1'b0, 1'b1, '{ST_ADDR,    16'd1023, 10'd0, 7'd1}},
      '{OP_ALLOC,   16'd1023,  17'd0,      1'b0, 1'b1, '{ST_ADDR,    16'd1025, 10'd0, 7'd2}},
      '{OP_FREE,    16'd0,     17'd0,      1'b1, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd2}},
      '{OP_FREE,    16'd0,     17'h1FFFF,  1'b0, 1'b1, '{ST_BADADDR, 16'd0,    10'd0, 7'd2}},
      '{OP_FREE,    16'hFFFF,  17'd65536,  1'b0, 1'b1, '{ST_BADADDR, 16'd0,    10'd0, 7'd2}},
      '{OP_FREE,    16'd0,     17'd2047,   1'b0, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd1}},
      '{OP_FREE,    16'd0,     17'd2048,   1'b0, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd1}},
      '{OP_REALLOC, 16'd0,     17'd0,      1'b0, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd0}},
      '{OP_REALLOC, 16'd5,     17'h1FFFF,  1'b1, 1'b0, '0},
      '{OP_REALLOC, 16'd100,   17'd1019,   1'b0, 1'b0, '0},
      '{OP_REALLOC, 16'd7,     17'd65536,  1'b0, 1'b1, '{ST_BADADDR, 16'd0,    10'd0, 7'd1}},
      '{OP_REALLOC, 16'd1024,  17'd1024,   1'b0, 1'b1, '{ST_OOM,     16'd0,    10'd0, 7'd1}},
      '{OP_REALLOC, 16'd0,     17'd0,      1'b1, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd1}},
      // old slot is free and is the list head: its size is rewritten first
      '{OP_REALLOC, 16'd3,     17'd100,    1'b0, 1'b0, '0},
      '{OpUnused,   16'd500,   17'd2000,   1'b0, 1'b1, '{ST_NULL,    16'd0,    10'd0, 7'd1}},
      '{OP_REALLOC, 16'd1000,  17'd1500,   1'b0, 1'b0, '0},
      '{OP_ALLOC,   16'd512,   17'd0,      1'b0, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].opc, directed_rows[i].size, directed_rows[i].a,
                   directed_rows[i].nul, directed_rows[i].typed, directed_rows[i].want);
    wait_for_results();

    // alternate fill and drain phases so the pool runs empty and full often
    for (int i = 0; i < RandomItems; i++) begin
      grow   = ((i / PhaseLen) % 2) == 0;
      steady = (i >= 1000 && i < 1300);

      k = $urandom_range(0, 99);
      if (k < (grow ? 55 : 20))      opc = OP_ALLOC;
      else if (k < (grow ? 80 : 40)) opc = OP_REALLOC;
      else if (k < (grow ? 96 : 95)) opc = OP_FREE;
      else                           opc = OpUnused;

      k = $urandom_range(0, 99);
      if (k < 5)       size = '0;
      else if (k < 10) size = SizeW'($urandom_range(SLOT_BYTES, SizeSpan));
      else if (k < 14) size = SizeW'(SLOT_BYTES - 1);
      else if (k < 18) size = SizeW'(1);
      else             size = SizeW'($urandom_range(1, SLOT_BYTES - 1));

      nul = 1'b0;
      k = $urandom_range(0, 99);
      if (k < 8) begin
        nul = 1'b1;
        a = AddrW'($urandom_range(0, AddrSpan));
      end else if (k < 16) begin
        a = AddrW'($urandom_range(PoolBytes, AddrSpan));
      end else if (k < 28 || use_count == 0) begin
        a = AddrW'($urandom_range(0, PoolBytes - 1));
      end else begin
        s = $urandom_range(0, NUM_SLOTS - 1);
        while (!in_use[s]) s = (s + 1) % NUM_SLOTS;
        if ($urandom_range(0, 99) < 60)
          a = AddrW'(s * SLOT_BYTES + SLOT_BYTES - slot_size[s]);
        else
          a = AddrW'(s * SLOT_BYTES + $urandom_range(0, SLOT_BYTES - 1));
      end

      // never reallocate from a slot whose size was never recorded, unless it is the head
      if (opc == OP_REALLOC && size != 0 && !nul && a < PoolBytes &&
          !size_known[a / SLOT_BYTES] && (a / SLOT_BYTES) != free_head)
        nul = 1'b1;

      send_request(opc, size, a, nul, 1'b0, '0);
      if (i == RandomItems / 2) wait_for_results();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests (%0d directed), %0d refused on an empty pool, peak use %0d of %0d",
             requests_sent, DirRows, empty_hits, peak_use, NUM_SLOTS);
    $display("results checked: %0d address, %0d null, %0d out of memory, %0d bad address",
             status_seen[ST_ADDR], status_seen[ST_NULL], status_seen[ST_OOM],
             status_seen[ST_BADADDR]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
